>>> src/idsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idsp_pkg
// shared constants and types for the incremental dag shortest path block
// ----------------------------------------------------------------------------
package idsp_pkg;

    // edge store word geometry
    localparam int WORD_BITS  = 64;
    localparam int WORD_SHIFT = 6;

    // field widths
    localparam int NODE_W = 8;
    localparam int DIST_W = 8;
    localparam int CFG_W  = 9;

    // node count limits
    localparam int DEF_MAX_NODES    = 256;
    localparam int MIN_NODES        = 3;
    localparam int NODE_COUNT_RESET = 256;

    // result of the lowest set bit search over one edge word
    typedef struct packed {
        logic                  hit;
        logic [WORD_SHIFT-1:0] idx;
    } pick_t;

endpackage
`default_nettype wire

>>> src/idsp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idsp_ram
// generic simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module idsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> src/idsp_pick.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idsp_pick
// lowest set bit finder over one edge word, byte level then bit level
// ----------------------------------------------------------------------------
module idsp_pick (
    input  wire logic [idsp_pkg::WORD_BITS-1:0] bits,
    output idsp_pkg::pick_t                     pick
);
    import idsp_pkg::*;

    localparam int BYTES = WORD_BITS / 8;
    localparam int BSW   = $clog2(BYTES);

    logic [BYTES-1:0] byte_any;
    logic [BSW-1:0]   byte_sel;
    logic [7:0]       byte_bits;
    logic [2:0]       bit_sel;

    always_comb
    begin
        for (int b = 0; b < BYTES; b++)
        begin
            byte_any[b] = |bits[b*8 +: 8];
        end

        // scan downward so the lowest nonzero byte wins
        byte_sel = '0;
        for (int b = BYTES - 1; b >= 0; b--)
        begin
            if (byte_any[b])
            begin
                byte_sel = BSW'(b);
            end
        end

        byte_bits = bits[byte_sel*8 +: 8];

        bit_sel = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (byte_bits[i])
            begin
                bit_sel = 3'(i);
            end
        end

        pick.hit = |byte_any;
        pick.idx = {byte_sel, bit_sel};
    end

endmodule
`default_nettype wire

>>> src/incremental_dag_shortest_path.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// incremental_dag_shortest_path
// adds one forward edge per transaction and relaxes distances to the last
// node in a backward sweep, returning the distance from node 0
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  cfg       in         cfg_valid / cfg_ready  node_count
//  in        in         in_valid / in_stall    from_node, to_node
//  out       out        out_valid / out_stall  shortest_distance
//
//  a transaction sweeps the rows backward, reading each row's edge words;
//  its length is set by the single read port of the distance memory and
//  one compare per stored edge
//  reset and every node_count write start a clearing pass over all
//  MAX_NODES * ceil(MAX_NODES / 64) edge words (1024 at 256 nodes), in_stall high
//  a finished result waits in the output register; one new input is taken
//  meanwhile and its result is held until the output register frees up
// ----------------------------------------------------------------------------
module incremental_dag_shortest_path #(
    parameter int MAX_NODES = idsp_pkg::DEF_MAX_NODES
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [idsp_pkg::CFG_W-1:0]   node_count,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [idsp_pkg::NODE_W-1:0]  from_node,
    input  wire logic [idsp_pkg::NODE_W-1:0]  to_node,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [idsp_pkg::DIST_W-1:0]       shortest_distance
);
    import idsp_pkg::*;

    localparam int ROW_WORDS  = (MAX_NODES + WORD_BITS - 1) / WORD_BITS;
    localparam int EDGE_DEPTH = MAX_NODES * ROW_WORDS;
    localparam int EAW        = $clog2(EDGE_DEPTH);
    localparam int DAW        = $clog2(MAX_NODES);
    localparam int DW         = DAW;
    localparam int NCW        = $clog2(MAX_NODES + 1);
    localparam int WIW        = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int XW         = EAW + 1;
    localparam int KW         = (NCW > CFG_W) ? NCW : CFG_W;
    localparam int NC_RST     = (NODE_COUNT_RESET > MAX_NODES) ? MAX_NODES
                                                               : NODE_COUNT_RESET;

    typedef enum logic [10:0] {
        ST_CLEAR     = 11'b000_0000_0001,
        ST_IDLE      = 11'b000_0000_0010,
        ST_INS_RD    = 11'b000_0000_0100,
        ST_INS_WR    = 11'b000_0000_1000,
        ST_ROW_RD    = 11'b000_0001_0000,
        ST_ROW_INIT  = 11'b000_0010_0000,
        ST_WORD_LOAD = 11'b000_0100_0000,
        ST_SCAN      = 11'b000_1000_0000,
        ST_CAND      = 11'b001_0000_0000,
        ST_ROW_WR    = 11'b010_0000_0000,
        ST_DONE      = 11'b100_0000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [NCW-1:0]        node_count_reg, node_count_next;
    logic [EAW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [DAW-1:0]        v_reg, v_next;
    logic [WIW-1:0]        w_reg, w_next;
    logic [WORD_BITS-1:0]  bits_reg, bits_next;
    logic [DW-1:0]         best_reg, best_next;
    logic [DW-1:0]         chain_reg, chain_next;
    logic [NODE_W-1:0]     from_reg, from_next;
    logic [NODE_W-1:0]     to_reg, to_next;
    logic                  ok_reg, ok_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]     out_data_reg, out_data_next;

    // memory ports
    logic                  edge_we;
    logic [EAW-1:0]        edge_waddr, edge_raddr;
    logic [WORD_BITS-1:0]  edge_wdata, edge_rdata;
    logic                  d_we;
    logic [DAW-1:0]        d_waddr, d_raddr;
    logic [DW-1:0]         d_wdata, d_rdata;

    pick_t                 pick;

    logic [NCW-1:0]        cfg_clamped;
    logic [EAW-1:0]        ins_addr;
    logic [DW-1:0]         clr_dist;
    logic [DAW:0]          v_plus1;
    logic [WIW-1:0]        w_start, w_last;
    logic [WIW+WORD_SHIFT-1:0] u_wide;
    logic [DW-1:0]         cand;
    logic [DW+DIST_W-1:0]  best_ext;

    function automatic logic [EAW-1:0] row_addr(input logic [DAW-1:0] v,
                                                input logic [WIW-1:0] w);
        row_addr = EAW'(v) * EAW'(ROW_WORDS) + EAW'(w);
    endfunction

    idsp_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (EDGE_DEPTH)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    idsp_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_NODES)
    ) u_dist_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    idsp_pick u_pick (
        .bits (bits_reg),
        .pick (pick)
    );

    always_comb
    begin
        if (KW'(node_count) < KW'(MIN_NODES))
        begin
            cfg_clamped = NCW'(MIN_NODES);
        end
        else if (KW'(node_count) > KW'(MAX_NODES))
        begin
            cfg_clamped = NCW'(MAX_NODES);
        end
        else
        begin
            cfg_clamped = NCW'(node_count);
        end
    end

    assign ins_addr = ok_reg ? EAW'(from_reg) * EAW'(ROW_WORDS) + EAW'(to_reg >> WORD_SHIFT)
                             : '0;
    assign clr_dist = (XW'(clr_cnt_reg) < XW'(node_count_reg))
                    ? DW'(XW'(node_count_reg) - XW'(1) - XW'(clr_cnt_reg)) : '0;
    assign v_plus1  = {1'b0, v_reg} + (DAW+1)'(1);
    assign w_start  = WIW'(v_plus1 >> WORD_SHIFT);
    assign w_last   = WIW'((node_count_reg - NCW'(1)) >> WORD_SHIFT);
    assign u_wide   = {w_reg, pick.idx};
    assign cand     = d_rdata + DW'(1);
    assign best_ext = {{DIST_W{1'b0}}, best_reg};

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        clr_cnt_next    = clr_cnt_reg;
        v_next          = v_reg;
        w_next          = w_reg;
        bits_next       = bits_reg;
        best_next       = best_reg;
        chain_next      = chain_reg;
        from_next       = from_reg;
        to_next         = to_reg;
        ok_next         = ok_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        edge_we    = 1'b0;
        edge_waddr = '0;
        edge_wdata = '0;
        edge_raddr = '0;
        d_we       = 1'b0;
        d_waddr    = '0;
        d_wdata    = '0;
        d_raddr    = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                edge_we    = 1'b1;
                edge_waddr = clr_cnt_reg;
                if (XW'(clr_cnt_reg) < XW'(MAX_NODES))
                begin
                    d_we    = 1'b1;
                    d_waddr = DAW'(clr_cnt_reg);
                    d_wdata = clr_dist;
                end
                if (clr_cnt_reg == EAW'(EDGE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + EAW'(1);
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    from_next  = from_node;
                    to_next    = to_node;
                    ok_next    = (from_node < to_node)
                              && (KW'(to_node) < KW'(node_count_reg));
                    state_next = ST_INS_RD;
                end
            end

            ST_INS_RD:
            begin
                edge_raddr = ins_addr;
                state_next = ST_INS_WR;
            end

            ST_INS_WR:
            begin
                if (ok_reg)
                begin
                    edge_we    = 1'b1;
                    edge_waddr = ins_addr;
                    edge_wdata = edge_rdata
                               | (WORD_BITS'(1) << to_reg[WORD_SHIFT-1:0]);
                end
                // last node sits at distance 0, so the first chain candidate is 1
                v_next     = DAW'(node_count_reg - NCW'(2));
                chain_next = DW'(1);
                state_next = ST_ROW_RD;
            end

            ST_ROW_RD:
            begin
                d_raddr    = v_reg;
                state_next = ST_ROW_INIT;
            end

            ST_ROW_INIT:
            begin
                best_next  = (chain_reg < d_rdata) ? chain_reg : d_rdata;
                w_next     = w_start;
                edge_raddr = row_addr(v_reg, w_start);
                state_next = ST_WORD_LOAD;
            end

            ST_WORD_LOAD:
            begin
                bits_next  = edge_rdata;
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (pick.hit)
                begin
                    d_raddr    = DAW'(u_wide);
                    bits_next  = bits_reg & ~(WORD_BITS'(1) << pick.idx);
                    state_next = ST_CAND;
                end
                else if (w_reg == w_last)
                begin
                    state_next = ST_ROW_WR;
                end
                else
                begin
                    w_next     = w_reg + WIW'(1);
                    edge_raddr = row_addr(v_reg, w_reg + WIW'(1));
                    state_next = ST_WORD_LOAD;
                end
            end

            ST_CAND:
            begin
                if (cand < best_reg)
                begin
                    best_next = cand;
                end
                state_next = ST_SCAN;
            end

            ST_ROW_WR:
            begin
                d_we    = 1'b1;
                d_waddr = v_reg;
                d_wdata = best_reg;
                // the row just finished is the chain neighbor of the next one
                chain_next = best_reg + DW'(1);
                if (v_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    v_next     = v_reg - DAW'(1);
                    state_next = ST_ROW_RD;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = best_ext[DIST_W-1:0];
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next   = ST_CLEAR;
                clr_cnt_next = '0;
            end
        endcase

        // node count write restarts the clearing pass
        if (cfg_valid)
        begin
            node_count_next = cfg_clamped;
            clr_cnt_next    = '0;
            state_next      = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            node_count_reg <= NCW'(NC_RST);
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            clr_cnt_reg    <= clr_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        w_reg        <= w_next;
        bits_reg     <= bits_next;
        best_reg     <= best_next;
        chain_reg    <= chain_next;
        from_reg     <= from_next;
        to_reg       <= to_next;
        ok_reg       <= ok_next;
        out_data_reg <= out_data_next;
    end

    assign cfg_ready         = 1'b1;
    assign in_stall          = (state_reg != ST_IDLE);
    assign out_valid         = out_valid_reg;
    assign shortest_distance = out_data_reg;

endmodule
`default_nettype wire

>>> src/idsp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idsp_checker
// port level checks on the incremental dag shortest path block
// ----------------------------------------------------------------------------
module idsp_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        cfg_valid,
    input wire logic                        cfg_ready,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [idsp_pkg::DIST_W-1:0] shortest_distance
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(shortest_distance))
        else $error("stalled result changed");

    // one transaction at a time: busy right after an accepted input
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !cfg_valid |=> in_stall)
        else $error("input taken while a sweep should be running");

    // a node count write starts the clearing pass
    a_clear_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> in_stall)
        else $error("input channel open during clearing pass");

    // a result only appears at the end of a busy period
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a sweep");

endmodule

bind incremental_dag_shortest_path idsp_checker u_idsp_checker (.*);
`default_nettype wire
